### sv/kfc_pkg.sv
// ============================================================================
// kfc_pkg
// Shared types, constants and helpers of the k-mer frequency counter.
// ============================================================================
`default_nettype none

package kfc_pkg;

    // Default sizes of the count table.
    localparam int MAX_K_DEF      = 8;
    localparam int COUNT_BITS_DEF = 32;

    // Field widths of the request, response and configuration channels.
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 16;
    localparam int KLEN_W   = 4;
    localparam int STRIDE_W = 16;
    localparam int OUT_W    = 32;
    localparam int RUN_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [KLEN_W-1:0]   KMER_LENGTH_RST = 4'd8;
    localparam logic [STRIDE_W-1:0] STRIDE_RST      = 16'd1;

    // Request operations.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KMER_LENGTH    = 2'd0,
        CFG_STRIDE         = 2'd1,
        CFG_CANONICAL_ONLY = 2'd2,
        CFG_UNIQUE_ONLY    = 2'd3
    } t_cfg_idx;

    // Letters of the four bases, both cases.
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

    // Two-bit base codes.
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // Decoded base letter.
    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_base;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept_push;
        logic accept_read;
        logic wr_a;
        logic wr_b;
        logic load_rsp;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic push_bump;
        logic pend_b;
        logic out_free;
    } t_dp_status;

    // Map an ASCII letter to its base code; anything else is not a base.
    function automatic t_base base_decode(input logic [CHAR_W-1:0] ch);
        t_base res;
        res.ok   = 1'b1;
        res.code = BASE_A;
        unique case (ch) inside
            CHAR_A_UP, CHAR_A_LO: res.code = BASE_A;
            CHAR_C_UP, CHAR_C_LO: res.code = BASE_C;
            CHAR_G_UP, CHAR_G_LO: res.code = BASE_G;
            CHAR_T_UP, CHAR_T_LO: res.code = BASE_T;
            default:              res.ok   = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/kfc_req_if.sv
// ============================================================================
// kfc_req_if
// Request channel: a base push or a table read.
// ============================================================================
`default_nettype none

interface kfc_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  base_char;
    logic        new_sequence;
    logic [15:0] read_index;

    modport source (output valid, operation, base_char, new_sequence, read_index,
                    input ready);
    modport sink   (input valid, operation, base_char, new_sequence, read_index,
                    output ready);
endinterface

`default_nettype wire

### sv/kfc_rsp_if.sv
// ============================================================================
// kfc_rsp_if
// Response channel: count of one table entry and its listing flag.
// ============================================================================
`default_nettype none

interface kfc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] count_value;
    logic        listed;

    modport source (output valid, count_value, listed, input ready);
    modport sink   (input valid, count_value, listed, output ready);
endinterface

`default_nettype wire

### sv/kfc_cfg_if.sv
// ============================================================================
// kfc_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface kfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/kfc_ctrl.sv
// ============================================================================
// kfc_ctrl
// Controller of the k-mer counter: clearing pass, request intake and the
// read-modify-write sequence on the count memory.
// ============================================================================
`default_nettype none

module kfc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_op,
    output logic                    o_in_ready,
    input  wire kfc_pkg::t_dp_status i_status,
    output kfc_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WR_A  = 5'b00100,
        S_WR_B  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_op == kfc_pkg::OP_READ) begin
                        o_cmd.accept_read = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        o_cmd.accept_push = 1'b1;
                        if (i_status.push_bump) begin
                            n_state = S_WR_A;
                        end
                    end
                end
            end
            S_WR_A: begin
                o_cmd.wr_a = 1'b1;
                n_state = i_status.pend_b ? S_WR_B : S_IDLE;
            end
            S_WR_B: begin
                o_cmd.wr_b = 1'b1;
                n_state = S_IDLE;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A read request always moves on to the response state.
    a_read_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_op == kfc_pkg::OP_READ) |=> (r_state == S_RESP))
        else $error("read request did not reach the response state");

    // A push that counts starts the memory update in the next cycle.
    a_push_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_op == kfc_pkg::OP_PUSH && i_status.push_bump)
        |=> (r_state == S_WR_A))
        else $error("counting push did not start a table update");

    // The first cycle after reset belongs to the clearing pass.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (r_state == S_CLEAR && !o_in_ready))
        else $error("clearing pass not running after reset");
`endif

endmodule

`default_nettype wire

### sv/kfc_datapath.sv
// ============================================================================
// kfc_datapath
// Datapath of the k-mer counter: configuration registers, rolling window
// codes, count memory with saturating update and the response register.
// ============================================================================
`default_nettype none

module kfc_datapath #(
    parameter int MAX_K      = kfc_pkg::MAX_K_DEF,
    parameter int COUNT_BITS = kfc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration writes.
    input  wire logic                              i_cfg_valid,
    input  wire logic [kfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [kfc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Request payload.
    input  wire logic [kfc_pkg::CHAR_W-1:0]        i_base_char,
    input  wire logic                              i_new_sequence,
    input  wire logic [kfc_pkg::INDEX_W-1:0]       i_read_index,
    // Response channel.
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [kfc_pkg::OUT_W-1:0]              o_count_value,
    output logic                                   o_listed,
    // Controller link.
    input  wire kfc_pkg::t_dp_cmd                  i_cmd,
    output kfc_pkg::t_dp_status                    o_status
);

    localparam int TB = 2 * MAX_K;
    localparam int SW = $clog2(TB + 1);
    localparam int KW = kfc_pkg::KLEN_W;
    localparam int RW = kfc_pkg::RUN_W;
    localparam int PW = kfc_pkg::STRIDE_W;

    // Configuration registers.
    logic [KW-1:0] r_kmer_length;
    logic [PW-1:0] r_stride;
    logic          r_canonical;
    logic          r_unique;

    // Window state.
    logic [TB-1:0] r_fwd;
    logic [TB-1:0] r_rev;
    logic [RW-1:0] r_run;
    logic [PW-1:0] r_phase;
    logic [RW-1:0] r_bases;

    // Update addresses of the request in flight.
    logic [TB-1:0]         r_addr_a;
    logic [TB-1:0]         r_addr_b;
    logic                  r_bump_b;
    logic [COUNT_BITS-1:0] r_wdata_a;

    // Count memory and its registered read data.
    logic [COUNT_BITS-1:0] r_mem [2**TB];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [TB-1:0]         r_clr_addr;

    // Response register.
    logic                  r_out_valid;
    logic [kfc_pkg::OUT_W-1:0] r_count;
    logic                  r_listed;

    // Combinational window step.
    kfc_pkg::t_base w_base;
    logic [KW-1:0]  w_k;
    logic [SW-1:0]  w_k2;
    logic [SW-1:0]  w_rc_sh;
    logic [TB-1:0]  w_kmask;
    logic [TB-1:0]  w_fwd_b;
    logic [TB-1:0]  w_rev_b;
    logic [RW-1:0]  w_run_b;
    logic [PW-1:0]  w_phase_b;
    logic [RW-1:0]  w_bases_b;
    logic [TB-1:0]  w_fwd_n;
    logic [TB-1:0]  w_rev_n;
    logic [RW-1:0]  w_run_n;
    logic [PW-1:0]  w_phase_n;
    logic [RW-1:0]  w_bases_n;
    logic [PW:0]    w_phase_nxt;
    logic           w_have_window;
    logic           w_take;
    logic           w_bump;
    logic [TB-1:0]  w_fw;
    logic [TB-1:0]  w_rc;
    logic [TB-1:0]  w_addr_a;
    logic           w_bump_a;
    logic           w_bump_b;

    // Memory access.
    logic                  w_rd_en;
    logic [TB-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [TB-1:0]         w_wr_addr;
    logic [COUNT_BITS-1:0] w_wr_data;
    logic [COUNT_BITS-1:0] w_inc_a;
    logic [COUNT_BITS-1:0] w_old_b;
    logic [COUNT_BITS-1:0] w_inc_b;
    logic                  w_listed;

    // Effective k: zero acts as one, values above MAX_K act as MAX_K.
    always_comb begin
        if (r_kmer_length == '0) begin
            w_k = KW'(1);
        end else if (r_kmer_length > KW'(MAX_K)) begin
            w_k = KW'(MAX_K);
        end else begin
            w_k = r_kmer_length;
        end
    end

    assign w_k2    = SW'({w_k, 1'b0});
    assign w_rc_sh = SW'(TB) - w_k2;
    assign w_kmask = ~({TB{1'b1}} << w_k2);

    // A new sequence starts from a cleared window.
    assign w_base    = kfc_pkg::base_decode(i_base_char);
    assign w_fwd_b   = i_new_sequence ? '0 : r_fwd;
    assign w_rev_b   = i_new_sequence ? '0 : r_rev;
    assign w_run_b   = i_new_sequence ? '0 : r_run;
    assign w_phase_b = i_new_sequence ? '0 : r_phase;
    assign w_bases_b = i_new_sequence ? '0 : r_bases;

    // Shift the base into both codes; a non-base only breaks the run.
    always_comb begin
        if (w_base.ok) begin
            w_fwd_n = (w_fwd_b << 2) | TB'(w_base.code);
            w_rev_n = (w_rev_b >> 2) | (TB'(~w_base.code) << (TB - 2));
            w_run_n = (w_run_b == '1) ? w_run_b : w_run_b + RW'(1);
        end else begin
            w_fwd_n = w_fwd_b;
            w_rev_n = w_rev_b;
            w_run_n = '0;
        end
    end

    // Window start phase and the position count of this sequence.
    assign w_have_window = ({1'b0, w_bases_b} + (RW + 1)'(1)) >= (RW + 1)'(w_k);
    assign w_phase_nxt   = {1'b0, w_phase_b} + (PW + 1)'(1);
    assign w_take        = w_have_window && (w_phase_b == '0);
    assign w_bases_n     = (w_bases_b == '1) ? w_bases_b : w_bases_b + RW'(1);

    always_comb begin
        if (!w_have_window) begin
            w_phase_n = w_phase_b;
        end else if (w_phase_nxt >= {1'b0, r_stride}) begin
            w_phase_n = '0;
        end else begin
            w_phase_n = w_phase_nxt[PW-1:0];
        end
    end

    // Forward and reverse-complement k-mers of the finished window.
    assign w_bump = w_take && (w_run_n >= w_k);
    assign w_fw   = w_fwd_n & w_kmask;
    assign w_rc   = w_rev_n >> w_rc_sh;

    // Canonical mode counts the lesser code once and skips palindromes.
    always_comb begin
        if (r_canonical) begin
            w_addr_a = (w_fw < w_rc) ? w_fw : w_rc;
            w_bump_a = w_bump && (w_fw != w_rc);
            w_bump_b = 1'b0;
        end else begin
            w_addr_a = w_fw;
            w_bump_a = w_bump;
            w_bump_b = w_bump;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= kfc_pkg::KMER_LENGTH_RST;
            r_stride      <= kfc_pkg::STRIDE_RST;
            r_canonical   <= 1'b0;
            r_unique      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (kfc_pkg::t_cfg_idx'(i_cfg_index))
                kfc_pkg::CFG_KMER_LENGTH:    r_kmer_length <= i_cfg_data[KW-1:0];
                kfc_pkg::CFG_STRIDE:         r_stride      <= i_cfg_data[PW-1:0];
                kfc_pkg::CFG_CANONICAL_ONLY: r_canonical   <= i_cfg_data[0];
                kfc_pkg::CFG_UNIQUE_ONLY:    r_unique      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Window state advances on each accepted push.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= '0;
            r_rev   <= '0;
            r_run   <= '0;
            r_phase <= '0;
            r_bases <= '0;
        end else if (i_cmd.accept_push) begin
            r_fwd   <= w_fwd_n;
            r_rev   <= w_rev_n;
            r_run   <= w_run_n;
            r_phase <= w_phase_n;
            r_bases <= w_bases_n;
        end
    end

    // Update addresses and the pending second update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump_b <= 1'b0;
        end else if (i_cmd.accept_push) begin
            r_bump_b <= w_bump_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_push) begin
            r_addr_a <= w_addr_a;
            r_addr_b <= w_rc;
        end
        if (i_cmd.wr_a) begin
            r_wdata_a <= w_inc_a;
        end
    end

    // Clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + TB'(1);
        end
    end

    // Saturating increments; the second update sees the first one when
    // both land on the same entry.
    assign w_inc_a = (r_rdata == '1) ? r_rdata : r_rdata + COUNT_BITS'(1);
    assign w_old_b = (r_addr_b == r_addr_a) ? r_wdata_a : r_rdata;
    assign w_inc_b = (w_old_b == '1) ? w_old_b : w_old_b + COUNT_BITS'(1);

    // Memory port selection.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_addr_a;
        if (i_cmd.accept_read) begin
            w_rd_en   = 1'b1;
            w_rd_addr = TB'(i_read_index);
        end else if (i_cmd.accept_push) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_addr_a;
        end else if (i_cmd.wr_a) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_addr_b;
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr_addr;
        w_wr_data = '0;
        if (i_cmd.clr_step) begin
            w_wr_en   = 1'b1;
        end else if (i_cmd.wr_a) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_addr_a;
            w_wr_data = w_inc_a;
        end else if (i_cmd.wr_b) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_addr_b;
            w_wr_data = w_inc_b;
        end
    end

    // Count memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Response register.
    assign w_listed = (r_rdata != '0) && (!r_unique || r_rdata == COUNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_rsp) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_count  <= kfc_pkg::OUT_W'(r_rdata);
            r_listed <= w_listed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count_value = r_count;
    assign o_listed      = r_listed;

    // Status to the controller.
    assign o_status.clr_last  = (r_clr_addr == '1);
    assign o_status.push_bump = w_bump_a;
    assign o_status.pend_b    = r_bump_b;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

`ifndef ASSERT_OFF
    // The memory write port serves one client at a time.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_step, i_cmd.wr_a, i_cmd.wr_b}))
        else $error("more than one memory write in a cycle");

    // A response is loaded only when the output register is free.
    a_rsp_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_rsp |-> (!r_out_valid || i_out_ready))
        else $error("response register overwritten");

    // Canonical mode never leaves a second update pending.
    a_canonical_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept_push && r_canonical) |=> !r_bump_b)
        else $error("second update pending in canonical mode");
`endif

endmodule

`default_nettype wire

### sv/kmer_frequency_counter.sv
// ============================================================================
// kmer_frequency_counter
// Counts k-mers of a DNA base stream in a saturating table of 4^MAX_K entries.
// ============================================================================
//
// Usage:
//   i_req carries one request at a time: a base push (operation 0) or a table
//   read (operation 1). i_cfg writes the four registers by index and is always
//   ready. o_rsp returns one count and listing flag for each read request.
//   A push that completes a counted window updates the count memory by
//   read-modify-write through its single write port: a push with no update
//   leaves the controller idle, one update (canonical mode) uses the first
//   write state and two updates (plain mode) use both, before the next
//   request is taken. A read registers the memory data and loads it into
//   the response register in its response state once that register is free.
//   The response register decouples the receiver: pushes are still taken
//   while a response waits; a later read holds in its response state until
//   the receiver takes the earlier one. After reset the block clears all
//   4^MAX_K entries (65536 at the default size), one entry per cycle;
//   requests wait for that pass, configuration writes are taken throughout.
// ============================================================================
`default_nettype none

module kmer_frequency_counter #(
    parameter int MAX_K      = kfc_pkg::MAX_K_DEF,
    parameter int COUNT_BITS = kfc_pkg::COUNT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kfc_req_if.sink    i_req,
    kfc_rsp_if.source  o_rsp,
    kfc_cfg_if.sink    i_cfg
);

    kfc_pkg::t_dp_cmd    w_cmd;
    kfc_pkg::t_dp_status w_status;
    logic                w_in_ready;

    // Channel handshakes.
    assign i_req.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    // Controller.
    kfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_op    (i_req.operation),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    kfc_datapath #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_base_char    (i_req.base_char),
        .i_new_sequence (i_req.new_sequence),
        .i_read_index   (i_req.read_index),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_count_value  (o_rsp.count_value),
        .o_listed       (o_rsp.listed),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench of the k-mer frequency counter.
// ============================================================================
// A local model of the count table follows every accepted base and register
// write and works out the count and listing flag of each table read. The
// responses from the block are checked field by field against those values,
// in order. Directed tests cover letter decoding, plain and canonical
// counting, register changes in the middle of a sequence and a long
// response stall. Random phases then sweep the registers through their
// extremes with mostly well-formed sequences.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_K           = kfc_pkg::MAX_K_DEF;
    localparam int          TABLE_BITS      = 2 * MAX_K;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
    localparam int          PUSH_SETTLE     = 8;
    localparam int          RSP_HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES     = 20;
    // The clearing pass after reset runs without a request; the limit is four times the table size.
    localparam int          WATCHDOG_LIMIT  = 4 * (1 << TABLE_BITS);
    localparam int          MAX_PRINTED     = 50;
    localparam logic [7:0]  CHAR_N          = "N";
    localparam logic [7:0]  CHAR_O          = "O";

    // One expected read response.
    typedef struct {
        logic [31:0] count;
        logic        listed;
    } t_count_reply;

    logic i_clk;
    logic i_rst_n;

    kfc_req_if req_if ();
    kfc_rsp_if rsp_if ();
    kfc_cfg_if cfg_if ();

    kmer_frequency_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Local copy of the count table, the rolling windows and the registers.
    logic [31:0]                  kmer_counts [0:(1 << TABLE_BITS) - 1];
    logic [TABLE_BITS-1:0]        fwd_window;
    logic [TABLE_BITS-1:0]        rc_window;
    logic [kfc_pkg::RUN_W-1:0]    acgt_run;
    logic [kfc_pkg::STRIDE_W-1:0] window_phase;
    logic [kfc_pkg::RUN_W-1:0]    seq_bases;
    logic [kfc_pkg::KLEN_W-1:0]   cur_klen;
    logic [kfc_pkg::STRIDE_W-1:0] cur_stride;
    logic                         cur_canon;
    logic                         cur_unique;

    t_count_reply                 pending_counts [$];
    logic [kfc_pkg::INDEX_W-1:0]  touched_entries [$];

    int  error_count  = 0;
    int  quiet_cycles = 0;
    bit  idle_on      = 1'b0;
    bit  hold_pending = 1'b0;
    bit  rsp_taken    = 1'b0;
    int  hold_left    = 0;
    int  stall_left   = 0;

    // Clock: 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Returns 1 and the two-bit code for A, C, G or T in either case.
    function automatic bit decode_letter(input logic [7:0] ch, output logic [1:0] code);
        code = kfc_pkg::BASE_A;
        case (ch) inside
            kfc_pkg::CHAR_A_UP, kfc_pkg::CHAR_A_LO: code = kfc_pkg::BASE_A;
            kfc_pkg::CHAR_C_UP, kfc_pkg::CHAR_C_LO: code = kfc_pkg::BASE_C;
            kfc_pkg::CHAR_G_UP, kfc_pkg::CHAR_G_LO: code = kfc_pkg::BASE_G;
            kfc_pkg::CHAR_T_UP, kfc_pkg::CHAR_T_LO: code = kfc_pkg::BASE_T;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Packs a k-mer string into its table index, first base high.
    function automatic logic [kfc_pkg::INDEX_W-1:0] kmer_index(input string s);
        logic [kfc_pkg::INDEX_W-1:0] idx;
        logic [1:0]                  code;
        idx = '0;
        for (int i = 0; i < s.len(); i++) begin
            void'(decode_letter(s[i], code));
            idx = {idx[kfc_pkg::INDEX_W-3:0], code};
        end
        return idx;
    endfunction

    // Clears the model to its state after reset.
    function automatic void clear_model();
        foreach (kmer_counts[i]) kmer_counts[i] = '0;
        fwd_window   = '0;
        rc_window    = '0;
        acgt_run     = '0;
        window_phase = '0;
        seq_bases    = '0;
        cur_klen     = kfc_pkg::KMER_LENGTH_RST;
        cur_stride   = kfc_pkg::STRIDE_RST;
        cur_canon    = 1'b0;
        cur_unique   = 1'b0;
        pending_counts.delete();
        touched_entries.delete();
    endfunction

    // Saturating increment of one count; remembers the entry for later reads.
    function automatic void bump_count(input logic [kfc_pkg::INDEX_W-1:0] idx);
        if (kmer_counts[idx] != COUNT_MAX) kmer_counts[idx]++;
        touched_entries.push_back(idx);
        if (touched_entries.size() > 64) void'(touched_entries.pop_front());
    endfunction

    // Register write as the block sees it.
    function automatic void apply_config(input logic [kfc_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [kfc_pkg::CFG_DATA_W-1:0] data);
        case (kfc_pkg::t_cfg_idx'(idx))
            kfc_pkg::CFG_KMER_LENGTH:    cur_klen   = data[kfc_pkg::KLEN_W-1:0];
            kfc_pkg::CFG_STRIDE:         cur_stride = data[kfc_pkg::STRIDE_W-1:0];
            kfc_pkg::CFG_CANONICAL_ONLY: cur_canon  = data[0];
            kfc_pkg::CFG_UNIQUE_ONLY:    cur_unique = data[0];
            default: ;
        endcase
    endfunction

    // Shifts one base into the windows and counts the window it completes.
    function automatic void apply_push(input logic [7:0] ch, input logic new_seq);
        int                    k;
        int                    nxt;
        logic [1:0]            code;
        bit                    take;
        logic [TABLE_BITS-1:0] kmask;
        logic [TABLE_BITS-1:0] fw;
        logic [TABLE_BITS-1:0] rc;
        k = int'(cur_klen);
        if (k < 1) k = 1;
        if (k > MAX_K) k = MAX_K;
        if (new_seq) begin
            fwd_window   = '0;
            rc_window    = '0;
            acgt_run     = '0;
            window_phase = '0;
            seq_bases    = '0;
        end
        // A letter outside ACGT still takes a position but breaks the run.
        if (decode_letter(ch, code)) begin
            fwd_window = {fwd_window[TABLE_BITS-3:0], code};
            rc_window  = {~code, rc_window[TABLE_BITS-1:2]};
            if (acgt_run != 4'd15) acgt_run++;
        end else begin
            acgt_run = '0;
        end
        // Only window starts on the stride grid are counted.
        take = 1'b0;
        if (int'(seq_bases) + 1 >= k) begin
            take         = (window_phase == '0);
            nxt          = int'(window_phase) + 1;
            window_phase = (nxt >= int'(cur_stride)) ? '0 : kfc_pkg::STRIDE_W'(nxt);
        end
        if (seq_bases != 4'd15) seq_bases++;
        if (take && int'(acgt_run) >= k) begin
            kmask = TABLE_BITS'((32'd1 << (2 * k)) - 32'd1);
            fw    = fwd_window & kmask;
            rc    = TABLE_BITS'(rc_window >> (2 * (MAX_K - k))) & kmask;
            if (cur_canon) begin
                // Palindromes have equal codes and are skipped.
                if (fw < rc) bump_count(fw);
                else if (rc < fw) bump_count(rc);
            end else begin
                bump_count(fw);
                bump_count(rc);
            end
        end
    endfunction

    // Expected response of a table read.
    function automatic t_count_reply lookup_entry(input logic [kfc_pkg::INDEX_W-1:0] idx);
        t_count_reply r;
        r.count  = kmer_counts[idx];
        r.listed = (r.count != '0) && (!cur_unique || r.count == 32'd1);
        return r;
    endfunction

    // Compares one accepted response with the oldest expectation.
    task automatic check_response();
        t_count_reply exp_r;
        if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected response count=%0d listed=%0b",
                                      rsp_if.count_value, rsp_if.listed));
        end else begin
            exp_r = pending_counts.pop_front();
            if (rsp_if.count_value !== exp_r.count) begin
                report_mismatch($sformatf("count_value %0d, expected %0d",
                                          rsp_if.count_value, exp_r.count));
            end
            if (rsp_if.listed !== exp_r.listed) begin
                report_mismatch($sformatf("listed %0b, expected %0b (count %0d)",
                                          rsp_if.listed, exp_r.listed, exp_r.count));
            end
        end
    endtask

    // Monitor: follows every handshake at the rising edge and runs the watchdog.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                moved     = 1'b1;
                rsp_taken = 1'b1;
                check_response();
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                apply_config(cfg_if.index, cfg_if.data);
            end
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                if (kfc_pkg::t_op'(req_if.operation) == kfc_pkg::OP_READ) begin
                    pending_counts.push_back(lookup_entry(req_if.read_index));
                end else begin
                    apply_push(req_if.base_char, req_if.new_sequence);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Response receiver: random stalls after each response while idle_on is set, plus a long
    // hold-off on request from a test.
    always @(negedge i_clk) begin
        if (hold_pending) begin
            hold_left    = RSP_HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (rsp_taken) begin
            stall_left = idle_on ? $urandom_range(0, 10) : 0;
            rsp_taken  = 1'b0;
        end
        if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
        end else begin
            rsp_if.ready = 1'b1;
        end
    end

    // Offers one request and returns at the falling edge after it is taken.
    task automatic send_request(input kfc_pkg::t_op op, input logic [7:0] ch,
                                input logic new_seq,
                                input logic [kfc_pkg::INDEX_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        = 1'b1;
        req_if.operation    = op;
        req_if.base_char    = ch;
        req_if.new_sequence = new_seq;
        req_if.read_index   = idx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_base(input logic [7:0] ch, input logic new_seq);
        send_request(kfc_pkg::OP_PUSH, ch, new_seq, kfc_pkg::INDEX_W'($urandom));
    endtask

    task automatic read_entry(input logic [kfc_pkg::INDEX_W-1:0] idx);
        send_request(kfc_pkg::OP_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    // Reads a recently counted entry most of the time, else any entry.
    task automatic read_some_entry();
        if (touched_entries.size() > 0 && $urandom_range(0, 9) < 7) begin
            read_entry(touched_entries[$urandom_range(0, touched_entries.size() - 1)]);
        end else begin
            read_entry(kfc_pkg::INDEX_W'($urandom));
        end
    endtask

    // Waits until every expected response has come and the last push is done.
    task automatic drain();
        req_if.valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (PUSH_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(input kfc_pkg::t_cfg_idx idx,
                                  input logic [kfc_pkg::CFG_DATA_W-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Writes all four registers once the block is idle; unused data bits
    // are random.
    task automatic set_mode(input logic [kfc_pkg::KLEN_W-1:0] klen,
                            input logic [kfc_pkg::STRIDE_W-1:0] stride,
                            input logic canon, input logic uniq);
        drain();
        write_register(kfc_pkg::CFG_KMER_LENGTH, {12'($urandom), klen});
        write_register(kfc_pkg::CFG_STRIDE, stride);
        write_register(kfc_pkg::CFG_CANONICAL_ONLY, {15'($urandom), canon});
        write_register(kfc_pkg::CFG_UNIQUE_ONLY, {15'($urandom), uniq});
    endtask

    function automatic logic [7:0] random_acgt();
        logic [7:0] letters [8];
        letters = '{kfc_pkg::CHAR_A_UP, kfc_pkg::CHAR_A_LO,
                    kfc_pkg::CHAR_C_UP, kfc_pkg::CHAR_C_LO,
                    kfc_pkg::CHAR_G_UP, kfc_pkg::CHAR_G_LO,
                    kfc_pkg::CHAR_T_UP, kfc_pkg::CHAR_T_LO};
        return letters[$urandom_range(0, 7)];
    endfunction

    function automatic logic [7:0] random_noise();
        case ($urandom_range(0, 2))
            0:       return CHAR_N;
            1:       return CHAR_O;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mixed case letters, N, O and bytes outside the alphabet in plain mode.
    task automatic test_letters_plain();
        string seq;
        idle_on = 1'b1;
        set_mode(4'd3, 16'd1, 1'b0, 1'b0);
        seq = "aCGtNcAgO";
        for (int i = 0; i < seq.len(); i++) push_base(seq[i], i == 0);
        push_base(8'hFF, 1'b0);
        push_base(8'h00, 1'b0);
        read_entry(kmer_index("ACG"));
        read_entry(kmer_index("CGT"));
        read_entry(kmer_index("CAG"));
        read_entry(16'hFFFF);
        // A read ignores new_sequence.
        send_request(kfc_pkg::OP_READ, 8'hFF, 1'b1, 16'h0000);
    endtask

    // Canonical counting with palindromes, and the unique-only listing.
    task automatic test_canonical_unique();
        string seq;
        set_mode(4'd2, 16'd1, 1'b1, 1'b1);
        seq = "ATGCAT";
        for (int i = 0; i < seq.len(); i++) push_base(seq[i], i == 0);
        read_entry(kmer_index("CA"));
        read_entry(kmer_index("AT"));
        read_entry(kmer_index("GC"));
        read_entry(kmer_index("TG"));
    endtask

    // Stride lowered and length shortened inside one sequence.
    task automatic test_midrun_changes();
        set_mode(4'd4, 16'd5, 1'b0, 1'b0);
        for (int i = 0; i < 9; i++) push_base(random_acgt(), i == 0);
        drain();
        write_register(kfc_pkg::CFG_STRIDE, 16'd2);
        for (int i = 0; i < 8; i++) push_base(random_acgt(), 1'b0);
        drain();
        write_register(kfc_pkg::CFG_KMER_LENGTH, 16'd2);
        for (int i = 0; i < 6; i++) push_base(random_acgt(), 1'b0);
        repeat (4) read_some_entry();
    endtask

    // Long receiver hold-off while requests keep coming, then a full drain.
    task automatic test_backpressure();
        set_mode(4'd3, 16'd1, 1'b0, 1'b0);
        idle_on      = 1'b0;
        hold_pending = 1'b1;
        @(negedge i_clk);
        read_some_entry();
        for (int i = 0; i < 6; i++) push_base(random_acgt(), i == 0);
        repeat (12) read_some_entry();
        drain();
        idle_on = 1'b1;
    endtask

    // Random phases over a sweep of register settings.
    task automatic test_random();
        logic [kfc_pkg::KLEN_W-1:0]   klens   [6];
        logic [kfc_pkg::STRIDE_W-1:0] strides [6];
        logic [kfc_pkg::KLEN_W-1:0]   klen;
        logic [kfc_pkg::STRIDE_W-1:0] stride;
        int                           sent;
        int                           seq_len;
        int                           roll;
        bit                           fresh;
        klens   = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd5};
        strides = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd1, 16'd2};
        for (int phase = 0; phase < 12; phase++) begin
            klen   = (phase < 6) ? klens[phase]
                                 : kfc_pkg::KLEN_W'($urandom_range(1, 8));
            stride = (phase < 6) ? strides[phase]
                                 : kfc_pkg::STRIDE_W'($urandom_range(1, 4));
            set_mode(klen, stride, 1'($urandom), 1'($urandom));
            idle_on = (phase % 3 != 2);
            sent    = 0;
            while (sent < 55) begin
                seq_len = $urandom_range(1, 24);
                // A few sequences carry on from the previous one.
                fresh = ($urandom_range(0, 9) != 0);
                for (int i = 0; i < seq_len && sent < 55; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 22) begin
                        read_some_entry();
                    end else if (roll < 27) begin
                        push_base(random_noise(), fresh && i == 0);
                    end else begin
                        push_base(random_acgt(), fresh && i == 0);
                    end
                    sent++;
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = kfc_pkg::OP_PUSH;
        req_if.base_char    = '0;
        req_if.new_sequence = 1'b0;
        req_if.read_index   = '0;
        rsp_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = kfc_pkg::CFG_KMER_LENGTH;
        cfg_if.data         = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_letters_plain();
        test_canonical_unique();
        test_midrun_changes();
        test_backpressure();
        test_random();

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_counts.size() != 0) begin
            report_mismatch($sformatf("%0d responses never arrived", pending_counts.size()));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
